// File: design/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg: shared types, constants and helpers of the Bezier flattener
// Point and segment widths, register codes, sequencer states, and the small
// arithmetic helpers used by the subdivision datapath.
// ----------------------------------------------------------------------------
package cbf_pkg;

  localparam int PT_W  = 24;
  localparam int SEG_W = 8 * PT_W;
  localparam int DEV_W = 26;
  localparam int SQ_W  = 2 * DEV_W;

  localparam logic       CFG_FLATNESS   = 1'b0;
  localparam logic       CFG_MAX_POINTS = 1'b1;
  localparam logic [31:0] LIMIT_RESET   = 32'd65536;
  localparam logic [6:0]  MAXPTS_RESET  = 7'd64;
  localparam logic [6:0]  MAXPTS_CAP    = 7'd64;

  typedef logic signed [PT_W-1:0] coord_t;
  typedef logic [SEG_W-1:0]       seg_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_READ,
    ST_MUL,
    ST_DECIDE,
    ST_PUSH_LO
  } state_t;

  // |3q - 2p - r|, fits 26 bits for 24-bit signed inputs
  function automatic logic [DEV_W-1:0] dev_mag(input coord_t p, input coord_t q,
                                               input coord_t r);
    logic signed [DEV_W:0] ep, eq, er, t;
    ep = (DEV_W+1)'(p);
    eq = (DEV_W+1)'(q);
    er = (DEV_W+1)'(r);
    t  = (eq <<< 1) + eq - (ep <<< 1) - er;
    return t[DEV_W] ? DEV_W'(-t) : t[DEV_W-1:0];
  endfunction

  // floor((a + b) / 2)
  function automatic coord_t halve(input coord_t a, input coord_t b);
    logic signed [PT_W:0] s;
    s = (PT_W+1)'(a) + (PT_W+1)'(b);
    return s[PT_W:1];
  endfunction

endpackage

// File: design/cbf_ram.sv
// ----------------------------------------------------------------------------
// cbf_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cbf_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/cubic_bezier_flattener.sv
// ----------------------------------------------------------------------------
// cubic_bezier_flattener: adaptive de Casteljau flattening of cubic curves
// Takes one cubic Bezier per input beat and emits its polyline vertices,
// start to end, on the output channel; the final vertex carries last.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_stall    | start, ctrl1, ctrl2, end (x and y)
//  out     | out_valid / out_stall  | out_x, out_y, last
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  Each popped segment passes through pop, RAM read, square and decide when
//  emitted, plus a second stack write when split, as set by the registered
//  stack read and its single write port. The block takes no new curve until
//  the last one is through: a curve is accepted, worked off, and closed by
//  one final pop before the next accept.
//  Reset clears the sequencer, stack pointer and output valid; the stack RAM
//  needs no clearing since every entry is written before it is read.
//  A stalled output holds the vertex; the next vertex parks the sequencer at decide.
//  Configuration is accepted every cycle; write it only while idle.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cbf_pkg::coord_t     start_x,
  input  cbf_pkg::coord_t     start_y,
  input  cbf_pkg::coord_t     ctrl1_x,
  input  cbf_pkg::coord_t     ctrl1_y,
  input  cbf_pkg::coord_t     ctrl2_x,
  input  cbf_pkg::coord_t     ctrl2_y,
  input  cbf_pkg::coord_t     end_x,
  input  cbf_pkg::coord_t     end_y,
  output logic                out_valid,
  input  logic                out_stall,
  output cbf_pkg::coord_t     out_x,
  output cbf_pkg::coord_t     out_y,
  output logic                last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);

  import cbf_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  state_t state, state_next;

  logic [31:0]    flatness_limit;
  logic [6:0]     max_points;
  logic [6:0]     budget;
  logic [6:0]     count;
  logic [SPW-1:0] sp;

  // current segment, points 0..3
  coord_t sx [4];
  coord_t sy [4];
  seg_word_t lo_seg;

  logic [DEV_W-1:0] du_x, dv_x, du_y, dv_y;
  logic [SQ_W-1:0]  qu_x, qv_x, qu_y, qv_y;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  seg_word_t       ram_wdata, ram_rdata;

  coord_t rx [4];
  coord_t ry [4];

  logic [SQ_W-1:0] mx, my;
  logic [SQ_W:0]   dev_sum;
  logic            flat, near_full, emit, can_load, go;
  logic [6:0]      count_inc;
  logic [6:0]      budget_in;
  coord_t          p1x, p2x, p3x, p4x, p5x, p6x;
  coord_t          p1y, p2y, p3y, p4y, p5y, p6y;
  seg_word_t       hi_word, lo_word;

  cbf_ram #(.WIDTH(SEG_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // unpack the word read from the stack
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rx[k] = ram_rdata[SEG_W - 1 - 2*k*PT_W -: PT_W];
      ry[k] = ram_rdata[SEG_W - 1 - (2*k+1)*PT_W -: PT_W];
    end
  end

  // flatness bound and split of the current segment
  always_comb begin
    mx        = (qu_x < qv_x) ? qv_x : qu_x;
    my        = (qu_y < qv_y) ? qv_y : qu_y;
    dev_sum   = (SQ_W+1)'(mx) + (SQ_W+1)'(my);
    flat      = dev_sum <= (SQ_W+1)'(flatness_limit);
    near_full = ((SPW+1)'(sp) + (SPW+1)'(2)) >= (SPW+1)'(STACK_DEPTH);
    emit      = flat || near_full;
    can_load  = !out_valid || !out_stall;
    go        = (sp != '0) && (count < budget);
    count_inc = count + 7'd1;

    p1x = halve(sx[0], sx[1]);
    p2x = halve(sx[1], sx[2]);
    p3x = halve(sx[2], sx[3]);
    p4x = halve(p1x, p2x);
    p5x = halve(p2x, p3x);
    p6x = halve(p4x, p5x);
    p1y = halve(sy[0], sy[1]);
    p2y = halve(sy[1], sy[2]);
    p3y = halve(sy[2], sy[3]);
    p4y = halve(p1y, p2y);
    p5y = halve(p2y, p3y);
    p6y = halve(p4y, p5y);
    hi_word = {p6x, p6y, p5x, p5y, p3x, p3y, sx[3], sy[3]};
    lo_word = {sx[0], sy[0], p1x, p1y, p4x, p4y, p6x, p6y};

    // clamp the vertex budget to 1..64
    if (max_points == 7'd0) begin
      budget_in = 7'd1;
    end else if (max_points > MAXPTS_CAP) begin
      budget_in = MAXPTS_CAP;
    end else begin
      budget_in = max_points;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_POP;
      ST_POP:     state_next = go ? ST_READ : ST_IDLE;
      ST_READ:    state_next = ST_MUL;
      ST_MUL:     state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (!emit) begin
          state_next = ST_PUSH_LO;
        end else if (can_load) begin
          state_next = ST_POP;
        end
      end
      ST_PUSH_LO: state_next = ST_POP;
      default:    state_next = ST_IDLE;
    endcase
  end

  // stack port and handshake outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(sp);
    ram_wdata = lo_seg;
    ram_raddr = AW'(sp - SPW'(1));
    in_stall  = (state != ST_IDLE);
    cfg_ready = 1'b1;
    case (state)
      ST_IDLE: begin
        ram_we    = in_valid;
        ram_waddr = '0;
        ram_wdata = {start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y};
      end
      ST_DECIDE: begin
        ram_we    = !emit;
        ram_wdata = hi_word;
      end
      ST_PUSH_LO: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(sp + SPW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      sp             <= '0;
      count          <= '0;
      budget         <= MAXPTS_RESET;
      out_valid      <= 1'b0;
      flatness_limit <= LIMIT_RESET;
      max_points     <= MAXPTS_RESET;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FLATNESS:   flatness_limit <= cfg_data;
          CFG_MAX_POINTS: max_points     <= cfg_data[6:0];
          default: ;
        endcase
      end

      // load a new vertex when the output is free, else drop the one taken
      if ((state == ST_DECIDE) && emit && can_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sp     <= SPW'(1);
            count  <= '0;
            budget <= budget_in;
          end
        end
        ST_POP: begin
          if (go) begin
            sp <= sp - SPW'(1);
          end
        end
        ST_DECIDE: begin
          if (emit && can_load) begin
            count <= count_inc;
          end
        end
        ST_PUSH_LO: sp <= sp + SPW'(2);
        default: ;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      for (int k = 0; k < 4; k++) begin
        sx[k] <= rx[k];
        sy[k] <= ry[k];
      end
      du_x <= dev_mag(rx[0], rx[1], rx[3]);
      dv_x <= dev_mag(rx[3], rx[2], rx[0]);
      du_y <= dev_mag(ry[0], ry[1], ry[3]);
      dv_y <= dev_mag(ry[3], ry[2], ry[0]);
    end
    if (state == ST_MUL) begin
      qu_x <= SQ_W'(du_x) * SQ_W'(du_x);
      qv_x <= SQ_W'(dv_x) * SQ_W'(dv_x);
      qu_y <= SQ_W'(du_y) * SQ_W'(du_y);
      qv_y <= SQ_W'(dv_y) * SQ_W'(dv_y);
    end
    if (state == ST_DECIDE) begin
      if (!emit) begin
        lo_seg <= lo_word;
      end else if (can_load) begin
        out_x <= sx[3];
        out_y <= sy[3];
        last  <= (count_inc == budget) || (sp == '0);
      end
    end
  end

endmodule

// File: test/tb_cubic_bezier_flattener.sv
// ----------------------------------------------------------------------------
// tb_cubic_bezier_flattener: self-checking bench for the Bezier flattener
// Drives cubic curves through a table of corner cases and then random phases
// under several flatness and vertex-budget settings. A built-in subdivision
// predictor produces the expected vertex stream; every output beat is checked
// in order against it while both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_flattener;
  timeunit 1ns;
  timeprecision 1ps;

  import cbf_pkg::*;

  localparam int  DEPTH   = 128;
  localparam longint CMAX = 64'sd8388607;
  localparam longint CMIN = -64'sd8388608;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } vertex_t;

  // one directed row: settings to run it under, the curve, and an optional
  // vertex that can be read off directly (a curve flat from the start)
  typedef struct {
    logic [31:0] limit;
    logic [31:0] maxpts;
    longint      pt[8];
    bit          known;
    longint      kx;
    longint      ky;
  } row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  coord_t      start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y;
  logic        out_valid;
  logic        out_stall;
  coord_t      out_x, out_y;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // predictor copy of the configuration
  logic [31:0] flat_limit;
  logic [6:0]  vertex_budget;

  vertex_t     pending_vertices[$];
  int          errors;
  int          curves_sent;
  int          vertices_seen;
  int          phases_run;
  bit          quiet;
  int          stall_left;

  cubic_bezier_flattener u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .ctrl1_x(ctrl1_x), .ctrl1_y(ctrl1_y),
    .ctrl2_x(ctrl2_x), .ctrl2_y(ctrl2_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous wall: far beyond the slowest legal run of all curves.
  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  // Flatten one curve the way the block should: pop, test flatness, emit the
  // end point or split at t=1/2, lower half on top so vertices run start-to-end.
  task automatic flatten_curve(input longint pt[8]);
    longint  stk[DEPTH][8];
    longint  s[8];
    longint  lo[8];
    longint  hi[8];
    longint  u, v, dsum, p1, p2, p3, p4, p5, p6;
    longint  dev[2];
    int      sp;
    int      budget;
    vertex_t run[$];
    vertex_t vx;
    budget = (vertex_budget == 0) ? 1 : (vertex_budget > MAXPTS_CAP) ? 64 : vertex_budget;
    stk[0] = pt;
    sp = 1;
    while (sp > 0 && run.size() < budget) begin
      sp--;
      s = stk[sp];
      for (int c = 0; c < 2; c++) begin
        u = 3 * s[2+c] - 2 * s[c] - s[6+c];
        v = 3 * s[4+c] - 2 * s[6+c] - s[c];
        u = u * u;
        v = v * v;
        dev[c] = (u < v) ? v : u;
      end
      dsum = dev[0] + dev[1];
      if (dsum <= longint'({32'd0, flat_limit}) || sp + 2 >= DEPTH) begin
        vx.x = coord_t'(s[6]);
        vx.y = coord_t'(s[7]);
        vx.last = 1'b0;
        run.push_back(vx);
      end else begin
        for (int c = 0; c < 2; c++) begin
          p1 = (s[c] + s[2+c]) >>> 1;
          p2 = (s[2+c] + s[4+c]) >>> 1;
          p3 = (s[4+c] + s[6+c]) >>> 1;
          p4 = (p1 + p2) >>> 1;
          p5 = (p2 + p3) >>> 1;
          p6 = (p4 + p5) >>> 1;
          lo[c] = s[c]; lo[2+c] = p1; lo[4+c] = p4; lo[6+c] = p6;
          hi[c] = p6;   hi[2+c] = p5; hi[4+c] = p3; hi[6+c] = s[6+c];
        end
        stk[sp] = hi;
        stk[sp+1] = lo;
        sp += 2;
      end
    end
    run[run.size()-1].last = 1'b1;
    foreach (run[i]) pending_vertices.push_back(run[i]);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FLATNESS) flat_limit = data;
    else vertex_budget = data[6:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Let every expected vertex arrive, then give the sequencer time to go idle.
  task automatic drain;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_mode(input logic [31:0] limit, input logic [31:0] maxpts);
    drain();
    write_reg(CFG_FLATNESS, limit);
    write_reg(CFG_MAX_POINTS, maxpts);
    phases_run++;
  endtask

  // Present one curve at the falling edge and hold it until accepted.
  task automatic send_curve(input longint pt[8], input bit known, input longint kx,
                            input longint ky);
    vertex_t vx;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start_x = coord_t'(pt[0]); start_y = coord_t'(pt[1]);
    ctrl1_x = coord_t'(pt[2]); ctrl1_y = coord_t'(pt[3]);
    ctrl2_x = coord_t'(pt[4]); ctrl2_y = coord_t'(pt[5]);
    end_x   = coord_t'(pt[6]); end_y   = coord_t'(pt[7]);
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (known) begin
      vx.x = coord_t'(kx);
      vx.y = coord_t'(ky);
      vx.last = 1'b1;
      pending_vertices.push_back(vx);
    end else begin
      flatten_curve(pt);
    end
    curves_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic random_curve(output longint pt[8]);
    longint base_x, base_y, span;
    int     mode;
    mode = $urandom_range(0, 9);
    base_x = longint'($urandom_range(0, 8388607)) - 64'sd4194304;
    base_y = longint'($urandom_range(0, 8388607)) - 64'sd4194304;
    span = longint'(1) << $urandom_range(2, 14);
    for (int i = 0; i < 8; i++) begin
      if (mode < 3) begin
        pt[i] = longint'(coord_t'($urandom));
      end else begin
        pt[i] = ((i % 2) ? base_y : base_x) + longint'($urandom_range(0, 2 * span)) - span;
      end
    end
    // straight segment with evenly spaced controls (up to rounding): flat at any threshold of 32 or more
    if (mode == 9) begin
      pt[2] = pt[0] + (pt[6] - pt[0]) / 3;
      pt[3] = pt[1] + (pt[7] - pt[1]) / 3;
      pt[4] = pt[2] + (pt[6] - pt[0]) / 3;
      pt[5] = pt[3] + (pt[7] - pt[1]) / 3;
    end
  endtask

  // Output stall: random bursts, none in the quiet tail.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && !rst && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Check every accepted vertex beat against the oldest prediction.
  always @(posedge clk) begin
    vertex_t want;
    if (!rst && out_valid && !out_stall) begin
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        report($sformatf("unexpected vertex (%0d,%0d) last=%0b", out_x, out_y, last));
      end else begin
        want = pending_vertices.pop_front();
        if (out_x !== want.x)
          report($sformatf("out_x %0d, want %0d", out_x, want.x));
        if (out_y !== want.y)
          report($sformatf("out_y %0d, want %0d", out_y, want.y));
        if (last !== want.last)
          report($sformatf("last %0b, want %0b", last, want.last));
      end
    end
  end

  initial begin
    row_t   rows[$];
    row_t   r;
    longint pt[8];
    logic [31:0] limits[7];
    logic [31:0] budgets[7];

    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FLATNESS;
    cfg_data = '0;
    {start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y} = '0;
    errors = 0;
    curves_sent = 0;
    vertices_seen = 0;
    phases_run = 0;
    quiet = 1'b0;
    stall_left = 0;
    flat_limit = LIMIT_RESET;
    vertex_budget = MAXPTS_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. Rows with a typed vertex are flat from the first pop.
    r.known = 0; r.kx = 0; r.ky = 0;
    r.limit = LIMIT_RESET; r.maxpts = MAXPTS_RESET;
    r.pt = '{0, 0, 0, 0, 0, 0, 0, 0}; r.known = 1; r.kx = 0; r.ky = 0;
    rows.push_back(r);
    r.pt = '{0, 0, 3, -3, 6, -6, 9, -9}; r.kx = 9; r.ky = -9;
    rows.push_back(r);
    r.pt = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}; r.kx = CMAX; r.ky = CMAX;
    rows.push_back(r);
    r.pt = '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}; r.kx = CMIN; r.ky = CMIN;
    rows.push_back(r);
    r.known = 0;
    r.pt = '{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX};
    rows.push_back(r);
    r.pt = '{CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX};
    rows.push_back(r);
    r.pt = '{0, 0, 0, 2560, 2560, 2560, 2560, 0};
    rows.push_back(r);
    // zero threshold: this curve reproduces itself in the lower half, so the
    // stack fills up and the nearly-full rule has to force emission
    r.limit = 0;
    r.pt = '{1, 0, 1, 0, 1, 0, 0, 0};
    rows.push_back(r);
    // upper half repeats forever: only the vertex budget stops it
    r.pt = '{0, 0, 0, 0, 0, 0, 1, 0};
    rows.push_back(r);
    r.maxpts = 1;
    r.pt = '{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN};
    rows.push_back(r);
    // budget 0 behaves as 1
    r.maxpts = 0;
    rows.push_back(r);
    r.limit = 32'hFFFF_FFFF; r.maxpts = 127;
    r.pt = '{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN};
    rows.push_back(r);
    r.maxpts = 64;
    r.pt = '{0, 0, 100, 100, 200, 0, 300, 300}; r.known = 1; r.kx = 300; r.ky = 300;
    rows.push_back(r);

    set_mode(LIMIT_RESET, MAXPTS_RESET);
    foreach (rows[i]) begin
      if (rows[i].limit != flat_limit || rows[i].maxpts[6:0] != vertex_budget)
        set_mode(rows[i].limit, rows[i].maxpts);
      send_curve(rows[i].pt, rows[i].known, rows[i].kx, rows[i].ky);
    end

    // Random phases; the last one runs without idling on either side.
    limits  = '{LIMIT_RESET, 0, 32'hFFFF_FFFF, $urandom, 4096, 32'h0010_0000, LIMIT_RESET};
    budgets = '{64, 7, 64, $urandom_range(1, 64), 0, 127, 64};
    for (int ph = 0; ph < 7; ph++) begin
      set_mode(limits[ph], budgets[ph]);
      quiet = (ph == 6);
      for (int n = 0; n < 37; n++) begin
        // hold the sender once until the block has delivered everything
        if (ph == 1 && n == 10) while (pending_vertices.size() != 0) @(posedge clk);
        random_curve(pt);
        send_curve(pt, 0, 0, 0);
      end
    end

    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d curves over %0d threshold/budget settings", curves_sent, phases_run);
    $display("checked %0d vertices, %0d mismatches", vertices_seen, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
